@@ rtl/core/block_mosaic_pixelate_top_defines.svh @@
// assertion macros shared by the mosaic pixelate checker
`ifndef BLOCK_MOSAIC_PIXELATE_TOP_DEFINES_SVH
`define BLOCK_MOSAIC_PIXELATE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BMP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bmp_pkg.sv @@
// types and constants of the mosaic pixelate block
package bmp_pkg;

  localparam int MAX_REGION_WIDTH  = 256;
  localparam int MAX_REGION_HEIGHT = 256;
  localparam int COORD_W = 8;
  localparam int REG_W   = 9;
  localparam int X_W     = $clog2(MAX_REGION_WIDTH);
  localparam int Y_W     = $clog2(MAX_REGION_HEIGHT);
  localparam int ADDR_W  = X_W + Y_W;
  localparam int PIX_W   = 24;
  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);

  localparam logic [REG_W-1:0] MIN_BLOCK   = REG_W'(2);
  localparam logic [REG_W-1:0] BLOCK_RESET = REG_W'(18);
  localparam logic [REG_W-1:0] WIDTH_RESET = REG_W'(MAX_REGION_WIDTH);
  localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(MAX_REGION_HEIGHT);

  // configuration register indexes
  localparam logic [1:0] REG_REGION_WIDTH  = 2'd0;
  localparam logic [1:0] REG_REGION_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_WIDTH   = 2'd2;
  localparam logic [1:0] REG_BLOCK_HEIGHT  = 2'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ
  } state_t;

  // two quotients and remainders sharing one divisor
  typedef struct packed {
    logic               busy;
    logic [COORD_W-1:0] q_a;
    logic [COORD_W-1:0] r_a;
    logic [COORD_W-1:0] q_b;
    logic [COORD_W-1:0] r_b;
  } div_out_t;

endpackage

@@ rtl/core/block_mosaic_pixelate_top.sv @@
// mosaic pixelate block: pixel store, block divider and sample addressing
// A write beat (tuser = 0) stores one BGR pixel at (pos_x, pos_y); the block is
// ready again on the next cycle and gives no result. A read beat (tuser = 1)
// returns the mosaicked colour of (pos_x, pos_y) with a covered flag, and holds
// the input closed while the bit-serial divider runs (8 quotient steps of
// x / block_width, y / block_height and of the region extents), then while it forms
// the sample address and reads the store. The result sits in an output register,
// so the next beat is taken while it waits; a read that finishes while an earlier
// result still waits there keeps the input closed until that result leaves.
// Coordinates beyond the region saturate to its last column and row; pixels must
// be written before they are read. The user must let configuration writes go in
// only while idle; the block itself does not enforce it.
module block_mosaic_pixelate_top
  import bmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // pos_x, pos_y, in_blue, in_green, in_red
  input  logic [0:0]           s_tuser,   // op
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [PIX_W-1:0]     m_tdata,   // out_blue, out_green, out_red
  output logic [0:0]           m_tuser    // covered
);

  // configuration registers
  logic [REG_W-1:0] region_width, region_height, block_width, block_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_width  <= WIDTH_RESET;
      region_height <= HEIGHT_RESET;
      block_width   <= BLOCK_RESET;
      block_height  <= BLOCK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_WIDTH:  region_width  <= cfg_data;
        REG_REGION_HEIGHT: region_height <= cfg_data;
        REG_BLOCK_WIDTH:   block_width   <= cfg_data;
        REG_BLOCK_HEIGHT:  block_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective region extents (last column and row) and block steps
  logic [COORD_W-1:0] wm1, hm1, x_c, y_c;
  logic [REG_W-1:0]   bw_c, bh_c;

  always_comb begin
    if (region_width > REG_W'(MAX_REGION_WIDTH)) begin
      wm1 = COORD_W'(MAX_REGION_WIDTH - 1);
    end else if (region_width == '0) begin
      wm1 = '0;
    end else begin
      wm1 = COORD_W'(region_width - REG_W'(1));
    end
    if (region_height > REG_W'(MAX_REGION_HEIGHT)) begin
      hm1 = COORD_W'(MAX_REGION_HEIGHT - 1);
    end else if (region_height == '0) begin
      hm1 = '0;
    end else begin
      hm1 = COORD_W'(region_height - REG_W'(1));
    end
    bw_c = (block_width  < MIN_BLOCK) ? MIN_BLOCK : block_width;
    bh_c = (block_height < MIN_BLOCK) ? MIN_BLOCK : block_height;
    // saturate coordinates to the region, for writes and reads alike
    x_c = (s_tdata[7:0]  > wm1) ? wm1 : s_tdata[7:0];
    y_c = (s_tdata[15:8] > hm1) ? hm1 : s_tdata[15:8];
  end

  // sequencer
  state_t state, state_next;
  logic   accept, div_start, mem_we, rd_en, out_load, out_free, div_busy;

  div_out_t div_x, div_y;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign div_busy = div_x.busy || div_y.busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == OP_READ) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = accept && (s_tuser == OP_READ);
    mem_we    = accept && (s_tuser == OP_WRITE);
    rd_en     = (state == ST_ADDR);
    out_load  = (state == ST_READ) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operands kept for the addressing step
  logic [COORD_W-1:0] x_r, y_r, wm1_r, hm1_r;
  logic [REG_W-1:0]   bw_r, bh_r;

  always_ff @(posedge clk) begin
    if (div_start) begin
      x_r   <= x_c;
      y_r   <= y_c;
      wm1_r <= wm1;
      hm1_r <= hm1;
      bw_r  <= bw_c;
      bh_r  <= bh_c;
    end
  end

  // lane a divides the coordinate, lane b the region extent, by the block step
  bmp_div u_div_x (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dvd_a   (x_c),
    .dvd_b   (wm1),
    .divisor (bw_c),
    .res     (div_x)
  );

  bmp_div u_div_y (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dvd_a   (y_c),
    .dvd_b   (hm1),
    .divisor (bh_c),
    .res     (div_y)
  );

  // sample position: the later block wins on shared edges, which comes down to
  // kx = min(x / bw + 1, kmax); kx * bw is rebuilt from remainders, no multiply
  logic               cov;
  logic [REG_W-1:0]   base_x, base_y, sx_full, sy_full;
  logic [COORD_W-1:0] sx, sy;

  always_comb begin
    // last covered column is kmax * bw = (w - 1) - rem_w
    cov = (div_x.q_b != '0) && (div_y.q_b != '0) &&
          (x_r <= wm1_r - div_x.r_b) && (y_r <= hm1_r - div_y.r_b);
    if (div_x.q_a < div_x.q_b) begin
      base_x = REG_W'(x_r) - REG_W'(div_x.r_a) + bw_r;
    end else begin
      base_x = REG_W'(wm1_r - div_x.r_b);
    end
    if (div_y.q_a < div_y.q_b) begin
      base_y = REG_W'(y_r) - REG_W'(div_y.r_a) + bh_r;
    end else begin
      base_y = REG_W'(hm1_r - div_y.r_b);
    end
    sx_full = base_x - {1'b0, bw_r[REG_W-1:1]};
    sy_full = base_y - {1'b0, bh_r[REG_W-1:1]};
    sx = cov ? sx_full[COORD_W-1:0] : x_r;
    sy = cov ? sy_full[COORD_W-1:0] : y_r;
  end

  // pixel store, blue in the low byte; no reset, so the user must write every pixel first
  logic [PIX_W-1:0] pixel_store [2**ADDR_W];
  logic [PIX_W-1:0] rd_data;
  logic             cov_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[{y_c[Y_W-1:0], x_c[X_W-1:0]}] <= s_tdata[39:16];
    end
    if (rd_en) begin
      rd_data <= pixel_store[{sy[Y_W-1:0], sx[X_W-1:0]}];
      cov_r   <= cov;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rd_data;
      m_tuser <= cov_r;
    end
  end

endmodule

@@ rtl/core/bmp_div.sv @@
// two-lane restoring divider, one quotient bit per cycle
module bmp_div
  import bmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] dvd_a,
  input  logic [COORD_W-1:0] dvd_b,
  input  logic [REG_W-1:0]   divisor,
  output div_out_t           res
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [REG_W-1:0]  dv;
  logic [COORD_W-1:0] qa, ra, qb, rb;
  logic [COORD_W-1:0] qa_next, ra_next, qb_next, rb_next;

  // partial remainder stays below the dividend range, so 8 bits hold it
  function automatic logic [2*COORD_W-1:0] div_step(
    input logic [COORD_W-1:0] rem,
    input logic [COORD_W-1:0] q,
    input logic [REG_W-1:0]   d
  );
    logic [REG_W-1:0]   trial;
    logic [COORD_W-1:0] rem_n;
    logic               bit_n;
    trial = {rem, q[COORD_W-1]};
    if (trial >= d) begin
      rem_n = COORD_W'(trial - d);
      bit_n = 1'b1;
    end else begin
      rem_n = trial[COORD_W-1:0];
      bit_n = 1'b0;
    end
    return {rem_n, q[COORD_W-2:0], bit_n};
  endfunction

  always_comb begin
    {ra_next, qa_next} = div_step(ra, qa, dv);
    {rb_next, qb_next} = div_step(rb, qb, dv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + STEP_W'(1);
      if (cnt == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa <= dvd_a;
      qb <= dvd_b;
      ra <= '0;
      rb <= '0;
      dv <= divisor;
    end else if (busy) begin
      qa <= qa_next;
      qb <= qb_next;
      ra <= ra_next;
      rb <= rb_next;
    end
  end

  assign res = '{busy: busy, q_a: qa, r_a: ra, q_b: qb, r_b: rb};

endmodule

@@ rtl/core/bmp_checker.sv @@
// port-level checker for the mosaic pixelate block, bound to the top level
`include "block_mosaic_pixelate_top_defines.svh"

module bmp_checker
  import bmp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [0:0]         s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [PIX_W-1:0]   m_tdata,
  input logic [0:0]         m_tuser
);

  // a stalled result stays offered
  `BMP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

  // a stalled result keeps its payload
  `BMP_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result payload changed while stalled")

  // a write beat never makes a result
  `BMP_ASSERT_NEXT(a_write_silent, clk, rst, s_tvalid && s_tready && s_tuser == OP_WRITE && !m_tvalid, !m_tvalid, "result appeared after a write beat")

  // a read beat closes the input while it is worked on
  `BMP_ASSERT_NEXT(a_read_busy, clk, rst, s_tvalid && s_tready && s_tuser == OP_READ, !s_tready, "input open during a read")

endmodule

bind block_mosaic_pixelate_top bmp_checker u_bmp_checker (.*);
